>>> src/htl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htl_pkg
// Shared types and constants of the hull tree / common ancestor engine.
// ----------------------------------------------------------------------------
package htl_pkg;

	localparam int FIELD_NODE_W = 12;
	localparam int FIELD_X_W    = 24;
	localparam int FIELD_H_W    = 37;
	localparam int DEPTH_W      = 12;
	localparam int LVL_W        = 5;
	localparam int RED_W        = 4;
	localparam int S_TDATA_W    = 104;
	localparam int M_TDATA_W    = 24;

	localparam logic [DEPTH_W-1:0] DEPTH_MAX = 12'd4095;
	localparam logic [RED_W-1:0]   RED_TOP   = 4'd11;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_STORE,
		ST_ROOT_ROW,
		ST_ROOT_PUSH,
		ST_POP_RD,
		ST_POP_PT,
		ST_POP_DIF,
		ST_POP_MUL,
		ST_POP_SUM,
		ST_POP_CMP,
		ST_PAR_RD,
		ST_PAR_DEP,
		ST_ROW0_WR,
		ST_ANC_RD,
		ST_ANC_WR,
		ST_PUSH,
		ST_Q_DEP,
		ST_Q_ORDER,
		ST_LIFT,
		ST_LIFT_WR,
		ST_CHECK,
		ST_CLIMB_RD,
		ST_CLIMB_CMP,
		ST_FINAL_RD,
		ST_FINAL,
		ST_DONE
	} st_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_REDUCE,
		OP_STORE_PT,
		OP_ROOT_ROW,
		OP_ROOT_PUSH,
		OP_POP_RD,
		OP_POP_PT,
		OP_POP_DIF,
		OP_POP_MUL,
		OP_POP_SUM,
		OP_POP_CMP,
		OP_PAR_RD,
		OP_PAR_DEP,
		OP_ROW0_WR,
		OP_ANC_RD,
		OP_ANC_WR,
		OP_PUSH,
		OP_Q_DEP,
		OP_Q_ORDER,
		OP_LIFT_RD,
		OP_LIFT_WR,
		OP_Q_EQ,
		OP_CLIMB_RD,
		OP_CLIMB_CMP,
		OP_FINAL_RD,
		OP_FINAL,
		OP_RESULT
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [LVL_W-1:0] lvl;
		logic [RED_W-1:0] red_k;
	} cmd_t;

	typedef struct packed {
		logic mode;
		logic root_case;
		logic cnt_gt1;
		logic cnt_gt2;
		logic below;
		logic diff_ge;
		logic a_eq_b;
		logic out_free;
	} sts_t;

endpackage

>>> src/htl_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htl_ctrl
// Sequencer: walks the point insert and ancestor query flows step by step.
// ----------------------------------------------------------------------------
module htl_ctrl import htl_pkg::*; #(
	parameter int LIFT_LEVELS = 12
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [LVL_W-1:0] LVL_TOP = LVL_W'(LIFT_LEVELS - 1);

	st_t              state_q, state_d;
	logic [LVL_W-1:0] lvl_q, lvl_d;
	logic [RED_W-1:0] k_q, k_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			lvl_q   <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			lvl_q   <= lvl_d;
			k_q     <= k_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		lvl_d     = lvl_q;
		k_d       = k_q;
		s_tready  = 1'b0;
		cmd.op    = OP_NONE;
		cmd.lvl   = lvl_q;
		cmd.red_k = k_q;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.op  = OP_LOAD;
					k_d     = RED_TOP;
					state_d = ST_REDUCE;
				end
			end
			ST_REDUCE: begin
				cmd.op = OP_REDUCE;
				k_d    = k_q - 1'b1;
				if (k_q == '0)
					state_d = sts.mode ? ST_Q_DEP : ST_STORE;
			end
			ST_STORE: begin
				cmd.op = OP_STORE_PT;
				lvl_d  = '0;
				if (sts.root_case)
					state_d = ST_ROOT_ROW;
				else if (sts.cnt_gt1)
					state_d = ST_POP_RD;
				else
					state_d = ST_PAR_RD;
			end
			ST_ROOT_ROW: begin
				cmd.op = OP_ROOT_ROW;
				lvl_d  = lvl_q + 1'b1;
				if (lvl_q == LVL_TOP)
					state_d = ST_ROOT_PUSH;
			end
			ST_ROOT_PUSH: begin
				cmd.op  = OP_ROOT_PUSH;
				state_d = ST_DONE;
			end
			ST_POP_RD: begin
				cmd.op  = OP_POP_RD;
				state_d = ST_POP_PT;
			end
			ST_POP_PT: begin
				cmd.op  = OP_POP_PT;
				state_d = ST_POP_DIF;
			end
			ST_POP_DIF: begin
				cmd.op  = OP_POP_DIF;
				state_d = ST_POP_MUL;
			end
			ST_POP_MUL: begin
				cmd.op  = OP_POP_MUL;
				state_d = ST_POP_SUM;
			end
			ST_POP_SUM: begin
				cmd.op  = OP_POP_SUM;
				state_d = ST_POP_CMP;
			end
			ST_POP_CMP: begin
				cmd.op  = OP_POP_CMP;
				state_d = (sts.below && sts.cnt_gt2) ? ST_POP_RD : ST_PAR_RD;
			end
			ST_PAR_RD: begin
				cmd.op  = OP_PAR_RD;
				state_d = ST_PAR_DEP;
			end
			ST_PAR_DEP: begin
				cmd.op  = OP_PAR_DEP;
				lvl_d   = '0;
				state_d = ST_ROW0_WR;
			end
			ST_ROW0_WR: begin
				cmd.op  = OP_ROW0_WR;
				lvl_d   = LVL_W'(1);
				state_d = (LVL_TOP == '0) ? ST_PUSH : ST_ANC_RD;
			end
			ST_ANC_RD: begin
				cmd.op  = OP_ANC_RD;
				state_d = ST_ANC_WR;
			end
			ST_ANC_WR: begin
				cmd.op = OP_ANC_WR;
				if (lvl_q == LVL_TOP) begin
					state_d = ST_PUSH;
				end else begin
					lvl_d   = lvl_q + 1'b1;
					state_d = ST_ANC_RD;
				end
			end
			ST_PUSH: begin
				cmd.op  = OP_PUSH;
				state_d = ST_DONE;
			end
			ST_Q_DEP: begin
				cmd.op  = OP_Q_DEP;
				state_d = ST_Q_ORDER;
			end
			ST_Q_ORDER: begin
				cmd.op  = OP_Q_ORDER;
				lvl_d   = LVL_TOP;
				state_d = ST_LIFT;
			end
			ST_LIFT: begin
				if (sts.diff_ge) begin
					cmd.op  = OP_LIFT_RD;
					state_d = ST_LIFT_WR;
				end else if (lvl_q == '0) begin
					state_d = ST_CHECK;
				end else begin
					lvl_d = lvl_q - 1'b1;
				end
			end
			ST_LIFT_WR: begin
				cmd.op  = OP_LIFT_WR;
				state_d = ST_LIFT;
			end
			ST_CHECK: begin
				lvl_d = LVL_TOP;
				if (sts.a_eq_b) begin
					cmd.op  = OP_Q_EQ;
					state_d = ST_DONE;
				end else begin
					state_d = ST_CLIMB_RD;
				end
			end
			ST_CLIMB_RD: begin
				cmd.op  = OP_CLIMB_RD;
				state_d = ST_CLIMB_CMP;
			end
			ST_CLIMB_CMP: begin
				cmd.op = OP_CLIMB_CMP;
				if (lvl_q == '0) begin
					state_d = ST_FINAL_RD;
				end else begin
					lvl_d   = lvl_q - 1'b1;
					state_d = ST_CLIMB_RD;
				end
			end
			ST_FINAL_RD: begin
				cmd.op  = OP_FINAL_RD;
				state_d = ST_FINAL;
			end
			ST_FINAL: begin
				cmd.op  = OP_FINAL;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.op  = OP_RESULT;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

>>> src/htl_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htl_datapath
// Point, stack, depth and ancestor memories, slope test and result register.
// ----------------------------------------------------------------------------
module htl_datapath import htl_pkg::*; #(
	parameter int MAX_NODES   = 4096,
	parameter int LIFT_LEVELS = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	output sts_t                 sts,
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  logic                 s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,
	output logic                 m_tuser
);

	localparam int NW        = $clog2(MAX_NODES);
	localparam int SCW       = $clog2(MAX_NODES + 1);
	localparam int ANC_DEPTH = MAX_NODES * LIFT_LEVELS;
	localparam int AW        = $clog2(ANC_DEPTH);
	localparam logic [AW-1:0]  LL    = AW'(LIFT_LEVELS);
	localparam logic [SCW-1:0] CNT_FULL = SCW'(MAX_NODES);

	// memories
	logic [FIELD_X_W-1:0] x_mem     [MAX_NODES];
	logic [FIELD_H_W-1:0] h_mem     [MAX_NODES];
	logic [NW-1:0]        stk_mem   [MAX_NODES];
	logic [DEPTH_W-1:0]   dep_mem   [MAX_NODES];
	logic [NW-1:0]        anc_mem   [ANC_DEPTH];

	// item registers
	logic                    mode_q, start_q;
	logic [FIELD_NODE_W-1:0] ri_q, ra_q, rb_q;
	logic [FIELD_X_W-1:0]    px_q;
	logic [FIELD_H_W-1:0]    ph_q;
	logic [SCW-1:0]          cnt_q;

	// read data
	logic [NW-1:0]        stk_rd0_q, stk_rd1_q;
	logic [FIELD_X_W-1:0] x_rd0_q, x_rd1_q;
	logic [FIELD_H_W-1:0] h_rd0_q, h_rd1_q;
	logic [DEPTH_W-1:0]   dep_rd0_q, dep_rd1_q;
	logic [NW-1:0]        anc_rd0_q, anc_rd1_q;

	// slope test
	logic signed [24:0] dx1_q, dx2_q;
	logic signed [37:0] dh1_q, dh2_q;
	logic               pos_q;
	logic signed [44:0] p1l_q, p2l_q;
	logic signed [43:0] p1h_q, p2h_q;
	logic signed [63:0] sum1_q, sum2_q;

	// tree walk
	logic [NW-1:0]      par_q, prev_q, qa_q, qb_q;
	logic [DEPTH_W-1:0] diff_q;

	// result staging and output
	logic [FIELD_NODE_W-1:0] res_node_q;
	logic [DEPTH_W-1:0]      res_dep_q;
	logic                    res_np_q;
	logic                    out_valid_q;
	logic [FIELD_NODE_W-1:0] out_node_q;
	logic [DEPTH_W-1:0]      out_dep_q;
	logic                    out_np_q;

	logic [NW-1:0]      ni, na, nb;
	logic [NW-1:0]      stk_ra0, stk_ra1, dep_ra0;
	logic [AW-1:0]      anc_ra0, anc_ra1, anc_wa;
	logic [NW-1:0]      anc_wd;
	logic               anc_we, dep_we;
	logic [DEPTH_W-1:0] dep_wd, d_new;
	logic [31:0]        lift_step;

	function automatic logic [FIELD_NODE_W-1:0] red_step(
		input logic [FIELD_NODE_W-1:0] v,
		input logic [RED_W-1:0]        k
	);
		logic [31:0] thr;
		thr = 32'(MAX_NODES) << k;
		if (32'(v) >= thr)
			return v - thr[FIELD_NODE_W-1:0];
		return v;
	endfunction

	assign ni = NW'(ri_q);
	assign na = NW'(ra_q);
	assign nb = NW'(rb_q);

	assign stk_ra0 = NW'(cnt_q - 1'b1);
	assign stk_ra1 = NW'(cnt_q - 2'd2);
	assign dep_ra0 = (cmd.op == OP_Q_DEP) ? na : stk_rd0_q;
	assign anc_wa  = AW'(ni) * LL + AW'(cmd.lvl);
	assign anc_ra1 = AW'(qb_q) * LL + AW'(cmd.lvl);
	assign d_new   = (dep_rd0_q >= DEPTH_MAX) ? DEPTH_MAX : dep_rd0_q + 1'b1;
	assign lift_step = 32'd1 << cmd.lvl;

	always_comb begin
		anc_ra0 = AW'(qa_q) * LL + AW'(cmd.lvl);
		if (cmd.op == OP_ANC_RD)
			anc_ra0 = AW'(prev_q) * LL + AW'(cmd.lvl - 1'b1);
		anc_we = 1'b0;
		anc_wd = ni;
		dep_we = 1'b0;
		dep_wd = '0;
		case (cmd.op)
			OP_ROOT_ROW: begin
				anc_we = 1'b1;
				dep_we = 1'b1;
			end
			OP_ROW0_WR: begin
				anc_we = 1'b1;
				anc_wd = par_q;
				dep_we = 1'b1;
				dep_wd = d_new;
			end
			OP_ANC_WR: begin
				anc_we = 1'b1;
				anc_wd = anc_rd0_q;
			end
			default: ;
		endcase
	end

	// memory ports
	always_ff @(posedge clk) begin
		if (cmd.op == OP_STORE_PT) begin
			x_mem[ni] <= px_q;
			h_mem[ni] <= ph_q;
		end
		x_rd0_q <= x_mem[stk_rd0_q];
		x_rd1_q <= x_mem[stk_rd1_q];
		h_rd0_q <= h_mem[stk_rd0_q];
		h_rd1_q <= h_mem[stk_rd1_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_ROOT_PUSH)
			stk_mem[0] <= ni;
		else if (cmd.op == OP_PUSH && cnt_q < CNT_FULL)
			stk_mem[NW'(cnt_q)] <= ni;
		stk_rd0_q <= stk_mem[stk_ra0];
		stk_rd1_q <= stk_mem[stk_ra1];
	end

	always_ff @(posedge clk) begin
		if (dep_we)
			dep_mem[ni] <= dep_wd;
		dep_rd0_q <= dep_mem[dep_ra0];
		dep_rd1_q <= dep_mem[nb];
	end

	always_ff @(posedge clk) begin
		if (anc_we)
			anc_mem[anc_wa] <= anc_wd;
		anc_rd0_q <= anc_mem[anc_ra0];
		anc_rd1_q <= anc_mem[anc_ra1];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (cmd.op)
				OP_ROOT_PUSH: cnt_q <= SCW'(1);
				OP_POP_CMP:   if (sts.below) cnt_q <= cnt_q - 1'b1;
				OP_PUSH:      if (cnt_q < CNT_FULL) cnt_q <= cnt_q + 1'b1;
				default: ;
			endcase
			if (cmd.op == OP_RESULT)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				mode_q  <= s_tuser;
				start_q <= s_tdata[0];
				ri_q    <= s_tdata[12:1];
				px_q    <= s_tdata[36:13];
				ph_q    <= s_tdata[73:37];
				ra_q    <= s_tdata[85:74];
				rb_q    <= s_tdata[97:86];
			end
			OP_REDUCE: begin
				ri_q <= red_step(ri_q, cmd.red_k);
				ra_q <= red_step(ra_q, cmd.red_k);
				rb_q <= red_step(rb_q, cmd.red_k);
			end
			OP_ROOT_PUSH: begin
				res_node_q <= '0;
				res_dep_q  <= '0;
				res_np_q   <= 1'b1;
			end
			OP_POP_DIF: begin
				dx1_q <= $signed({1'b0, x_rd0_q}) - $signed({1'b0, px_q});
				dx2_q <= $signed({1'b0, x_rd1_q}) - $signed({1'b0, x_rd0_q});
				dh1_q <= $signed({1'b0, h_rd0_q}) - $signed({1'b0, ph_q});
				dh2_q <= $signed({1'b0, h_rd1_q}) - $signed({1'b0, h_rd0_q});
			end
			OP_POP_MUL: begin
				// split the height difference so each product stays narrow
				pos_q <= (dx1_q > 0) && (dx2_q > 0);
				p1l_q <= $signed({1'b0, dh1_q[18:0]}) * dx2_q;
				p1h_q <= $signed(dh1_q[37:19]) * dx2_q;
				p2l_q <= $signed({1'b0, dh2_q[18:0]}) * dx1_q;
				p2h_q <= $signed(dh2_q[37:19]) * dx1_q;
			end
			OP_POP_SUM: begin
				sum1_q <= (64'(p1h_q) <<< 19) + 64'(p1l_q);
				sum2_q <= (64'(p2h_q) <<< 19) + 64'(p2l_q);
			end
			OP_PAR_DEP: par_q <= stk_rd0_q;
			OP_ROW0_WR: begin
				prev_q     <= par_q;
				res_node_q <= FIELD_NODE_W'(par_q);
				res_dep_q  <= d_new;
				res_np_q   <= 1'b0;
			end
			OP_ANC_WR: prev_q <= anc_rd0_q;
			OP_Q_ORDER: begin
				if (dep_rd0_q < dep_rd1_q) begin
					qa_q   <= nb;
					qb_q   <= na;
					diff_q <= dep_rd1_q - dep_rd0_q;
				end else begin
					qa_q   <= na;
					qb_q   <= nb;
					diff_q <= dep_rd0_q - dep_rd1_q;
				end
			end
			OP_LIFT_WR: begin
				qa_q   <= anc_rd0_q;
				diff_q <= diff_q - lift_step[DEPTH_W-1:0];
			end
			OP_Q_EQ: begin
				res_node_q <= FIELD_NODE_W'(qa_q);
				res_dep_q  <= '0;
				res_np_q   <= 1'b0;
			end
			OP_CLIMB_CMP: begin
				if (anc_rd0_q != anc_rd1_q) begin
					qa_q <= anc_rd0_q;
					qb_q <= anc_rd1_q;
				end
			end
			OP_FINAL: begin
				res_node_q <= FIELD_NODE_W'(anc_rd0_q);
				res_dep_q  <= '0;
				res_np_q   <= 1'b0;
			end
			OP_RESULT: begin
				out_node_q <= res_node_q;
				out_dep_q  <= res_dep_q;
				out_np_q   <= res_np_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		sts.mode      = mode_q;
		sts.root_case = start_q || (cnt_q == '0);
		sts.cnt_gt1   = cnt_q > SCW'(1);
		sts.cnt_gt2   = cnt_q > SCW'(2);
		sts.below     = pos_q && (sum1_q < sum2_q);
		sts.diff_ge   = 32'(diff_q) >= lift_step;
		sts.a_eq_b    = qa_q == qb_q;
		sts.out_free  = !out_valid_q || m_tready;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_dep_q, out_node_q};
	assign m_tuser  = out_np_q;

endmodule

>>> src/hull_tree_lca_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hull_tree_lca_engine
// Upper convex hull tree builder with binary lifting common ancestor queries.
// ----------------------------------------------------------------------------
// Input stream s_*: s_tuser selects the item (0 add point, 1 query); s_tdata
// carries the point or the two query nodes. Points come from the highest
// index down. Output stream m_*: one transfer per input item, holding the
// parent and depth of an added point (m_tuser set for a root) or the common
// ancestor of a query.
// One item is worked on at a time. An add runs one slope test per popped
// hull entry and one more unless the stack runs down to one entry, then
// writes the ancestor rows of the new point; a root writes its rows to
// itself. A query lifts the deeper node and, unless the lifted node meets
// the other, climbs both nodes level by level. Each item first goes through
// index range reduction.
// Reset empties the hull stack and output register; stored points, depths
// and ancestor rows hold garbage until written. When m_tready is low the
// finished result waits in the output register while the next item is
// taken and worked on; it is only held at its end until the register frees.
// ----------------------------------------------------------------------------
module hull_tree_lca_engine import htl_pkg::*; #(
	parameter int MAX_NODES   = 4096,
	parameter int LIFT_LEVELS = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// starts_chain, point_index, point_x, point_height, first_node,
	// second_node, zero fill
	input  logic [S_TDATA_W-1:0] s_tdata,
	// mode
	input  logic                 s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// result_node, result_depth
	output logic [M_TDATA_W-1:0] m_tdata,
	// no_parent
	output logic                 m_tuser
);

	cmd_t cmd;
	sts_t sts;

	htl_ctrl #(
		.LIFT_LEVELS(LIFT_LEVELS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	htl_datapath #(
		.MAX_NODES  (MAX_NODES),
		.LIFT_LEVELS(LIFT_LEVELS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.sts     (sts),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

endmodule
